// ===== sv/cjtm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cjtm_pkg: shared types and constants of the cron job table matcher
// Entry layout, operation and result codes, sequencer states, emit bundle.
// ----------------------------------------------------------------------------
package cjtm_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int ID_W        = 5;

  typedef enum logic [1:0] {
    MODE_TICK = 2'd0,
    MODE_ADD  = 2'd1,
    MODE_DEL  = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    KIND_MATCH    = 3'd0,
    KIND_NONE     = 3'd1,
    KIND_ADDED    = 3'd2,
    KIND_FULL     = 3'd3,
    KIND_DELETED  = 3'd4,
    KIND_NOTFOUND = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic [5:0]      minute;
    logic [4:0]      hour;
    logic [4:0]      mday;
    logic [3:0]      month_number;
    logic [2:0]      weekday;
    logic [4:0]      any_mask;
  } entry_t;

  typedef struct packed {
    logic            valid;
    kind_t           kind;
    logic [ID_W-1:0] entry_id;
    logic            last;
  } emit_t;

endpackage

// ===== sv/cjtm_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cjtm_if: item channels of the cron job table matcher
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface cjtm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [5:0] minute;
  logic [4:0] hour;
  logic [4:0] mday;
  logic [3:0] month_number;
  logic [2:0] weekday;
  logic [4:0] any_mask;
  logic [4:0] target_id;

  modport source (output valid, output mode, output minute, output hour,
                  output mday, output month_number, output weekday,
                  output any_mask, output target_id, input ready);
  modport sink (input valid, input mode, input minute, input hour,
                input mday, input month_number, input weekday,
                input any_mask, input target_id, output ready);
endinterface

interface cjtm_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [4:0] entry_id;
  logic       last;

  modport source (output valid, output kind, output entry_id, output last,
                  input ready);
  modport sink (input valid, input kind, input entry_id, input last,
                output ready);
endinterface

// ===== sv/cjtm_entry_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cjtm_entry_ram: schedule entry store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module cjtm_entry_ram (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [cjtm_pkg::IDX_W-1:0] wr_addr,
  input  cjtm_pkg::entry_t      wr_data,
  input  logic                  rd_en,
  input  logic [cjtm_pkg::IDX_W-1:0] rd_addr,
  output cjtm_pkg::entry_t      rd_data
);
  import cjtm_pkg::*;

  entry_t mem [MAX_ENTRIES];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/cjtm_out_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cjtm_out_reg: result output register
// Hold one result item until the sink takes it.
// ----------------------------------------------------------------------------
module cjtm_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  cjtm_pkg::emit_t   emit,
  output logic              slot_free,
  cjtm_out_if.source        out_ch
);
  import cjtm_pkg::*;

  logic            valid_r, valid_nxt;
  kind_t           kind_r;
  logic [ID_W-1:0] id_r;
  logic            last_r;

  assign slot_free = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (emit.valid) begin
      valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid) begin
      kind_r <= emit.kind;
      id_r   <= emit.entry_id;
      last_r <= emit.last;
    end
  end

  assign out_ch.valid    = valid_r;
  assign out_ch.kind     = kind_r;
  assign out_ch.entry_id = id_r;
  assign out_ch.last     = last_r;

endmodule

// ===== sv/cjtm_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cjtm_seq: table sequencer
// Walk the entry store for ticks and deletes, append on add, close gaps.
// ----------------------------------------------------------------------------
module cjtm_seq (
  input  logic                       clk,
  input  logic                       rst_n,
  cjtm_in_if.sink                    in_ch,
  input  logic                       slot_free,
  output cjtm_pkg::emit_t            emit,
  output logic                       wr_en,
  output logic [cjtm_pkg::IDX_W-1:0] wr_addr,
  output cjtm_pkg::entry_t           wr_data,
  output logic                       rd_en,
  output logic [cjtm_pkg::IDX_W-1:0] rd_addr,
  input  cjtm_pkg::entry_t           rd_data
);
  import cjtm_pkg::*;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [MAX_ENTRIES-1:0] used_r, used_nxt;
  logic             op_tick_r, op_tick_nxt;
  logic             pend_valid_r, pend_valid_nxt;
  logic [ID_W-1:0]  pend_id_r, pend_id_nxt;
  kind_t            fin_kind_r, fin_kind_nxt;
  logic [ID_W-1:0]  fin_id_r, fin_id_nxt;

  logic [5:0]       t_min_r;
  logic [4:0]       t_hour_r;
  logic [4:0]       t_day_r;
  logic [3:0]       t_month_r;
  logic [2:0]       t_wday_r;
  logic [ID_W-1:0]  tid_r;

  logic             accept;
  mode_t            in_mode;
  logic [IDX_W-1:0] last_idx;
  logic [IDX_W-1:0] idx_inc;
  logic             at_end;
  logic             shift_end;
  logic             tick_hit;
  logic             del_hit;
  logic             tick_stall;
  logic [IDX_W-1:0] free_idx;
  logic [ID_W-1:0]  free_id;
  logic [ID_W-1:0]  in_tid_m1;
  logic             in_tid_ok;
  logic [ID_W-1:0]  tid_m1;
  logic             tbl_full;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && (state_r == ST_IDLE);
  assign in_mode     = mode_t'(in_ch.mode);

  assign last_idx  = IDX_W'(cnt_r - CNT_W'(1));
  assign idx_inc   = idx_r + IDX_W'(1);
  assign at_end    = (idx_r == last_idx);
  assign shift_end = (idx_inc == last_idx);
  assign tbl_full  = (cnt_r == CNT_W'(MAX_ENTRIES));

  assign tick_hit = (rd_data.any_mask[0] || rd_data.minute       == t_min_r)   &&
                    (rd_data.any_mask[1] || rd_data.hour         == t_hour_r)  &&
                    (rd_data.any_mask[2] || rd_data.mday         == t_day_r)   &&
                    (rd_data.any_mask[3] || rd_data.month_number == t_month_r) &&
                    (rd_data.any_mask[4] || rd_data.weekday      == t_wday_r);
  assign del_hit    = (rd_data.id == tid_r);
  assign tick_stall = op_tick_r && tick_hit && pend_valid_r && !slot_free;

  assign in_tid_m1 = in_ch.target_id - ID_W'(1);
  assign in_tid_ok = (in_ch.target_id != '0) &&
                     (in_ch.target_id <= ID_W'(MAX_ENTRIES)) &&
                     used_r[in_tid_m1[IDX_W-1:0]];
  assign tid_m1    = tid_r - ID_W'(1);

  always_comb begin
    free_idx = '0;
    for (int k = MAX_ENTRIES - 1; k >= 0; k--) begin
      if (!used_r[k]) begin
        free_idx = IDX_W'(k);
      end
    end
  end
  assign free_id = ID_W'(free_idx) + ID_W'(1);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_mode)
            MODE_TICK: state_nxt = (cnt_r == '0) ? ST_DONE : ST_SCAN;
            MODE_ADD:  state_nxt = ST_DONE;
            MODE_DEL:  state_nxt = in_tid_ok ? ST_SCAN : ST_DONE;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        if (op_tick_r) begin
          if (!tick_stall && at_end) begin
            state_nxt = ST_DONE;
          end
        end else if (del_hit) begin
          state_nxt = at_end ? ST_DONE : ST_SHIFT;
        end else if (at_end) begin
          state_nxt = ST_DONE;
        end
      end
      ST_SHIFT: begin
        if (shift_end) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt        = cnt_r;
    idx_nxt        = idx_r;
    used_nxt       = used_r;
    op_tick_nxt    = op_tick_r;
    pend_valid_nxt = pend_valid_r;
    pend_id_nxt    = pend_id_r;
    fin_kind_nxt   = fin_kind_r;
    fin_id_nxt     = fin_id_r;
    rd_en          = 1'b0;
    rd_addr        = idx_inc;
    wr_en          = 1'b0;
    wr_addr        = idx_r;
    wr_data        = rd_data;
    emit           = '0;
    emit.kind      = KIND_MATCH;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          idx_nxt        = '0;
          pend_valid_nxt = 1'b0;
          op_tick_nxt    = (in_mode == MODE_TICK);
          rd_en          = 1'b1;
          rd_addr        = '0;
          case (in_mode)
            MODE_TICK: begin
              fin_kind_nxt = KIND_NONE;
              fin_id_nxt   = '0;
            end
            MODE_ADD: begin
              if (tbl_full) begin
                fin_kind_nxt = KIND_FULL;
                fin_id_nxt   = '0;
              end else begin
                wr_en                = 1'b1;
                wr_addr              = cnt_r[IDX_W-1:0];
                wr_data.id           = free_id;
                wr_data.minute       = in_ch.minute;
                wr_data.hour         = in_ch.hour;
                wr_data.mday         = in_ch.mday;
                wr_data.month_number = in_ch.month_number;
                wr_data.weekday      = in_ch.weekday;
                wr_data.any_mask     = in_ch.any_mask;
                cnt_nxt              = cnt_r + CNT_W'(1);
                used_nxt[free_idx]   = 1'b1;
                fin_kind_nxt         = KIND_ADDED;
                fin_id_nxt           = free_id;
              end
            end
            MODE_DEL: begin
              fin_kind_nxt = KIND_NOTFOUND;
              fin_id_nxt   = '0;
            end
            default: rd_en = 1'b0;
          endcase
        end
      end
      ST_SCAN: begin
        if (op_tick_r) begin
          if (!tick_stall) begin
            if (tick_hit) begin
              if (pend_valid_r) begin
                emit.valid    = 1'b1;
                emit.kind     = KIND_MATCH;
                emit.entry_id = pend_id_r;
                emit.last     = 1'b0;
              end
              pend_valid_nxt = 1'b1;
              pend_id_nxt    = rd_data.id;
            end
            if (at_end) begin
              if (tick_hit || pend_valid_r) begin
                fin_kind_nxt = KIND_MATCH;
                fin_id_nxt   = tick_hit ? rd_data.id : pend_id_r;
              end else begin
                fin_kind_nxt = KIND_NONE;
                fin_id_nxt   = '0;
              end
            end else begin
              rd_en   = 1'b1;
              idx_nxt = idx_inc;
            end
          end
        end else if (del_hit) begin
          if (at_end) begin
            cnt_nxt                     = cnt_r - CNT_W'(1);
            used_nxt[tid_m1[IDX_W-1:0]] = 1'b0;
            fin_kind_nxt                = KIND_DELETED;
            fin_id_nxt                  = tid_r;
          end else begin
            rd_en = 1'b1;
          end
        end else if (!at_end) begin
          rd_en   = 1'b1;
          idx_nxt = idx_inc;
        end
      end
      ST_SHIFT: begin
        wr_en   = 1'b1;
        idx_nxt = idx_inc;
        if (shift_end) begin
          cnt_nxt                     = cnt_r - CNT_W'(1);
          used_nxt[tid_m1[IDX_W-1:0]] = 1'b0;
          fin_kind_nxt                = KIND_DELETED;
          fin_id_nxt                  = tid_r;
        end else begin
          rd_en   = 1'b1;
          rd_addr = idx_r + IDX_W'(2);
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          emit.valid    = 1'b1;
          emit.kind     = fin_kind_r;
          emit.entry_id = fin_id_r;
          emit.last     = 1'b1;
        end
      end
      default: begin
        emit.valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      used_r       <= '0;
      pend_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      used_r       <= used_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    op_tick_r  <= op_tick_nxt;
    pend_id_r  <= pend_id_nxt;
    fin_kind_r <= fin_kind_nxt;
    fin_id_r   <= fin_id_nxt;
    if (accept) begin
      t_min_r   <= in_ch.minute;
      t_hour_r  <= in_ch.hour;
      t_day_r   <= in_ch.mday;
      t_month_r <= in_ch.month_number;
      t_wday_r  <= in_ch.weekday;
      tid_r     <= in_ch.target_id;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_ENTRIES))
    else $error("entry count above table depth");

  a_used_pop: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(used_r) == int'(cnt_r))
    else $error("id map out of step with entry count");

  a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN || state_r == ST_SHIFT) |-> (cnt_r != '0 && idx_r <= last_idx))
    else $error("table walk beyond stored entries");

  a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    emit.valid |-> slot_free)
    else $error("result item pushed into a busy output register");

  a_shift_write: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && state_r == ST_SHIFT) |-> (rd_addr != wr_addr || !rd_en))
    else $error("gap close reads the entry it writes");

endmodule

// ===== sv/cron_job_table_matcher.sv =====
`timescale 1ns / 1ps
// Adds, full-table adds and deletes of absent ids go straight to the result; a tick or a
// found delete walks the table and closes the gap one entry per cycle on the store's
// single read port, unless a tick's match has to wait for the output register.
// Throughput: one item at a time, the next taken once the last result of the one before
// has entered the output register. Reset (synchronous, active low) empties the table
// and frees all ids; the entry store is not cleared.
// ----------------------------------------------------------------------------
// cron_job_table_matcher: cron schedule entry table with time matching
// Add, delete and tick items against an insertion-ordered entry table.
// ----------------------------------------------------------------------------
module cron_job_table_matcher (
  input  logic        clk,
  input  logic        rst_n,
  cjtm_in_if.sink     in_ch,
  cjtm_out_if.source  out_ch
);
  import cjtm_pkg::*;

  emit_t            emit;
  logic             slot_free;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  entry_t           rd_data;

  cjtm_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .slot_free (slot_free),
    .emit      (emit),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  cjtm_entry_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  cjtm_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .emit      (emit),
    .slot_free (slot_free),
    .out_ch    (out_ch)
  );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the cron job table matcher
// Drives add, delete and tick items, and items of the unused mode, with random gaps on both channels and
// keeps a shadow schedule table that predicts every result in order.
// ----------------------------------------------------------------------------
module tb_top;
  import cjtm_pkg::*;

  localparam logic [1:0] MODE_UNUSED  = 2'd3;
  localparam int         STALL_LIMIT  = 2000;
  localparam int         DRAIN_CYCLES = 40;
  localparam int         HOLD_CYCLES  = 400;
  localparam int         RANDOM_ITEMS = 385;

  typedef struct packed {
    logic [1:0] mode;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [4:0] mday;
    logic [3:0] month_number;
    logic [2:0] weekday;
    logic [4:0] any_mask;
    logic [4:0] target_id;
  } item_t;

  typedef struct {
    kind_t      kind;
    logic [4:0] entry_id;
    logic       last;
  } result_t;

  class cron_table_scoreboard;
    entry_t  sched_q[$];
    result_t pending_q[$];
    int errors, n_tick, n_match, n_add, n_full, n_del, n_miss, n_results;

    function bit time_hits(entry_t e, item_t t);
      return (e.any_mask[0] || e.minute == t.minute) &&
             (e.any_mask[1] || e.hour == t.hour) &&
             (e.any_mask[2] || e.mday == t.mday) &&
             (e.any_mask[3] || e.month_number == t.month_number) &&
             (e.any_mask[4] || e.weekday == t.weekday);
    endfunction

    function bit id_taken(int id);
      foreach (sched_q[i]) if (sched_q[i].id == id) return 1'b1;
      return 1'b0;
    endfunction

    function void push(kind_t kind, logic [4:0] id, logic last);
      result_t r;
      r.kind = kind;
      r.entry_id = id;
      r.last = last;
      pending_q.insert(pending_q.size(), r);
    endfunction

    function void note_item(item_t it);
      logic [4:0] hits[$];
      entry_t e;
      int cand;
      bit found;
      case (it.mode)
        MODE_TICK: begin
          n_tick++;
          foreach (sched_q[i])
            if (time_hits(sched_q[i], it)) hits.insert(hits.size(), sched_q[i].id);
          if (hits.size() == 0) push(KIND_NONE, 5'd0, 1'b1);
          foreach (hits[i]) push(KIND_MATCH, hits[i], i == hits.size() - 1);
          n_match += hits.size();
        end
        MODE_ADD: begin
          if (sched_q.size() >= MAX_ENTRIES) begin
            n_full++;
            push(KIND_FULL, 5'd0, 1'b1);
          end else begin
            n_add++;
            for (cand = 1; cand <= sched_q.size(); cand++) if (!id_taken(cand)) break;
            e.id = 5'(cand);
            e.minute = it.minute;
            e.hour = it.hour;
            e.mday = it.mday;
            e.month_number = it.month_number;
            e.weekday = it.weekday;
            e.any_mask = it.any_mask;
            sched_q.insert(sched_q.size(), e);
            push(KIND_ADDED, e.id, 1'b1);
          end
        end
        MODE_DEL: begin
          found = 1'b0;
          foreach (sched_q[i]) begin
            if (!found && sched_q[i].id == it.target_id) begin
              found = 1'b1;
              sched_q.delete(i);
              break;
            end
          end
          if (found) begin
            n_del++;
            push(KIND_DELETED, it.target_id, 1'b1);
          end else begin
            n_miss++;
            push(KIND_NOTFOUND, 5'd0, 1'b1);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [2:0] kind, logic [4:0] entry_id, logic last);
      result_t exp;
      n_results++;
      if (pending_q.size() == 0) begin
        $error("unexpected result: kind %0d entry_id %0d last %0d", kind, entry_id, last);
        errors++;
        return;
      end
      exp = pending_q.pop_front();
      if (kind !== exp.kind) begin
        $error("kind: expected %0d, got %0d", exp.kind, kind);
        errors++;
      end
      if (entry_id !== exp.entry_id) begin
        $error("entry_id: expected %0d, got %0d", exp.entry_id, entry_id);
        errors++;
      end
      if (last !== exp.last) begin
        $error("last: expected %0d, got %0d", exp.last, last);
        errors++;
      end
    endfunction
  endclass

  bit   clk;
  logic rst_n;
  bit   in_quiet;
  bit   out_quiet;
  int   idle_cycles;

  cron_table_scoreboard sb = new();

  cjtm_in_if  in_ch();
  cjtm_out_if out_ch();

  cron_job_table_matcher DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic item_t mk(logic [1:0] mode, logic [5:0] mi, logic [4:0] hr,
                               logic [4:0] dm, logic [3:0] mo, logic [2:0] wd,
                               logic [4:0] mask, logic [4:0] tid);
    item_t it;
    it.mode = mode;
    it.minute = mi;
    it.hour = hr;
    it.mday = dm;
    it.month_number = mo;
    it.weekday = wd;
    it.any_mask = mask;
    it.target_id = tid;
    return it;
  endfunction

  function automatic item_t random_item(int add_pct);
    item_t it;
    entry_t e;
    int r, b;
    it.minute = 6'($urandom);
    it.hour = 5'($urandom);
    it.mday = 5'($urandom);
    it.month_number = 4'($urandom);
    it.weekday = 3'($urandom);
    it.any_mask = 5'($urandom);
    it.target_id = 5'($urandom);
    if ($urandom_range(0, 2) != 0) begin
      it.minute = 6'($urandom_range(0, 59));
      it.hour = 5'($urandom_range(0, 23));
      it.mday = 5'($urandom_range(1, 31));
      it.month_number = 4'($urandom_range(1, 12));
      it.weekday = 3'($urandom_range(0, 7));
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      it.mode = MODE_UNUSED;
    end else if (r < 3 + add_pct) begin
      it.mode = MODE_ADD;
    end else if (r < 28 + add_pct) begin
      it.mode = MODE_DEL;
      if (sb.sched_q.size() > 0 && $urandom_range(0, 3) != 0)
        it.target_id = sb.sched_q[$urandom_range(0, sb.sched_q.size() - 1)].id;
    end else begin
      it.mode = MODE_TICK;
      if (sb.sched_q.size() > 0 && $urandom_range(0, 4) != 0) begin
        e = sb.sched_q[$urandom_range(0, sb.sched_q.size() - 1)];
        it.minute = e.minute;
        it.hour = e.hour;
        it.mday = e.mday;
        it.month_number = e.month_number;
        it.weekday = e.weekday;
        if ($urandom_range(0, 3) == 0) begin
          b = $urandom_range(0, 2);
          case ($urandom_range(0, 4))
            0: it.minute[b] = ~it.minute[b];
            1: it.hour[b] = ~it.hour[b];
            2: it.mday[b] = ~it.mday[b];
            3: it.month_number[b] = ~it.month_number[b];
            default: it.weekday[b] = ~it.weekday[b];
          endcase
        end
      end
    end
    return it;
  endfunction

  task automatic send_item(input item_t it);
    int gap;
    gap = in_quiet ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.mode         <= it.mode;
    in_ch.minute       <= it.minute;
    in_ch.hour         <= it.hour;
    in_ch.mday         <= it.mday;
    in_ch.month_number <= it.month_number;
    in_ch.weekday      <= it.weekday;
    in_ch.any_mask     <= it.any_mask;
    in_ch.target_id    <= it.target_id;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  initial begin
    int k, add_pct;
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.mode         <= MODE_TICK;
    in_ch.minute       <= '0;
    in_ch.hour         <= '0;
    in_ch.mday         <= '0;
    in_ch.month_number <= '0;
    in_ch.weekday      <= '0;
    in_ch.any_mask     <= '0;
    in_ch.target_id    <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(mk(MODE_TICK, 0, 0, 0, 0, 0, 0, 0));
    send_item(mk(MODE_DEL, 0, 0, 0, 0, 0, 0, 0));
    send_item(mk(MODE_UNUSED, 6'h3f, 5'h1f, 5'h1f, 4'hf, 3'h7, 5'h1f, 5'h1f));
    send_item(mk(MODE_ADD, 6'h3f, 5'h1f, 5'h1f, 4'hf, 3'h7, 5'h00, 0));
    send_item(mk(MODE_ADD, 0, 0, 0, 0, 0, 5'h1f, 0));
    send_item(mk(MODE_TICK, 6'h3f, 5'h1f, 5'h1f, 4'hf, 3'h7, 0, 0));
    send_item(mk(MODE_DEL, 0, 0, 0, 0, 0, 0, 1));
    send_item(mk(MODE_ADD, 59, 23, 31, 12, 7, 5'b10101, 0));
    for (k = 0; k < 14; k++)
      send_item(mk(MODE_ADD, 6'(k * 4), 5'(k), 5'(k + 1), 4'(k % 12 + 1), 3'(k % 8),
                   5'h1f, 0));
    send_item(mk(MODE_ADD, 1, 1, 1, 1, 1, 0, 0));
    send_item(mk(MODE_TICK, 0, 23, 0, 12, 0, 0, 0));
    send_item(mk(MODE_DEL, 0, 0, 0, 0, 0, 0, 7));
    send_item(mk(MODE_ADD, 30, 12, 15, 6, 3, 5'b01010, 0));

    add_pct = 40;
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % 30 == 0) begin
        case ($urandom_range(0, 2))
          0: add_pct = 10;
          1: add_pct = 40;
          default: add_pct = 70;
        endcase
        in_quiet = ($urandom_range(0, 3) == 0);
      end
      send_item(random_item(add_pct));
    end
    in_ch.valid <= 1'b0;

    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d ticks with %0d matches, %0d adds, %0d adds on a full table,",
             sb.n_tick, sb.n_match, sb.n_add, sb.n_full);
    $display("%0d deletes and %0d deletes of absent ids; %0d results checked.",
             sb.n_del, sb.n_miss, sb.n_results);
    if (sb.errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin
    int gap, taken;
    taken = 0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (taken % 25 == 0) out_quiet = ($urandom_range(0, 3) == 0);
      gap = out_quiet ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      taken++;
      if (taken == 60) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    item_t seen;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        seen.mode = in_ch.mode;
        seen.minute = in_ch.minute;
        seen.hour = in_ch.hour;
        seen.mday = in_ch.mday;
        seen.month_number = in_ch.month_number;
        seen.weekday = in_ch.weekday;
        seen.any_mask = in_ch.any_mask;
        seen.target_id = in_ch.target_id;
        sb.note_item(seen);
      end
      if (out_ch.valid && out_ch.ready)
        sb.check_result(out_ch.kind, out_ch.entry_id, out_ch.last);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Timeout: no item moved for %0d cycles", idle_cycles);
        $display("Mismatches found");
        $finish;
      end
    end else begin
      idle_cycles <= 0;
    end
  end

endmodule

// ===== sim.f =====
sv/cjtm_pkg.sv
sv/cjtm_if.sv
sv/cjtm_entry_ram.sv
sv/cjtm_out_reg.sv
sv/cjtm_seq.sv
sv/cron_job_table_matcher.sv
tb/tb_top.sv
